>>> rtl/core/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation pipeline.
// Depends on nothing; imported by quaternion_vector_rotate and the testbench.
package qvr_pkg;

   // Quaternion components are signed Q2.14 at every vector width.
   localparam int Q_WIDTH = 16;
   localparam int Q_FRAC  = 14;
   localparam int P_WIDTH = 2 * Q_WIDTH;   // one quaternion product
   localparam int M_WIDTH = P_WIDTH + 2;   // one rotation matrix entry
   localparam int M_SPLIT = 16;            // low part of a matrix entry, unsigned

   typedef logic signed [Q_WIDTH-1:0] quat_type;
   typedef logic signed [M_WIDTH-1:0] m_type;

   // Every pairwise quaternion product that the matrix needs.
   typedef struct packed {
      logic signed [P_WIDTH-1:0] xx;
      logic signed [P_WIDTH-1:0] yy;
      logic signed [P_WIDTH-1:0] zz;
      logic signed [P_WIDTH-1:0] ww;
      logic signed [P_WIDTH-1:0] xy;
      logic signed [P_WIDTH-1:0] xz;
      logic signed [P_WIDTH-1:0] yz;
      logic signed [P_WIDTH-1:0] wx;
      logic signed [P_WIDTH-1:0] wy;
      logic signed [P_WIDTH-1:0] wz;
   } prod_type;

endpackage

>>> rtl/core/quaternion_vector_rotate.sv
// Quaternion vector rotation: five-stage pipeline, one transfer per cycle.
// Depends on qvr_pkg for the quaternion format and the product struct.
//
// Usage:
//   The req channel carries one rotation per transfer: a quaternion in signed
//   Q2.14 and a vector of DATA_WIDTH-bit signed components in tdata, and the
//   mode in tuser (1 rotates forward, 0 rotates by the conjugate). The rsp
//   channel returns the rotated vector in the input's scale, rounded to
//   nearest (ties up), with tuser set when any component was clipped.
//   Projected gravity is the conjugate mode with v = (0, 0, -1).
//   From the req transfer to rsp_tvalid the stages are: products of
//   quaternion pairs, matrix entries, matrix-by-vector partial products, row
//   sums, then the rounding add and clip. A new item may enter every cycle;
//   no stage has a busy state of its own, so only the receiver can slow it.
//   When the receiver stalls, a stage holds only while it is full and the
//   stage after it holds, so empty stages keep filling and req_tready drops
//   only once the whole pipeline is full. Nothing is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline; no other state.
module quaternion_vector_rotate #(
   parameter int DATA_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // qx, qy, qz, qw (16 bits each), vx, vy, vz (DATA_WIDTH each), zero pad
   input  logic [((4 * qvr_pkg::Q_WIDTH + 3 * DATA_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // cmd
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rx, ry, rz (DATA_WIDTH each), zero pad
   output logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   // saturated
   output logic rsp_tuser
);
   import qvr_pkg::*;

   localparam int RSP_W = ((3 * DATA_WIDTH + 7) / 8) * 8;
   localparam int LO_W  = M_SPLIT;
   localparam int HI_W  = M_WIDTH - M_SPLIT;
   localparam int PH_W  = HI_W + DATA_WIDTH;
   localparam int PL_W  = LO_W + 1 + DATA_WIDTH;
   localparam int SA_W  = PH_W + 2;
   localparam int SB_W  = (PL_W + 2 > 2 * Q_FRAC + 1) ? PL_W + 3 : 2 * Q_FRAC + 2;
   localparam int T_W   = SA_W + LO_W + 1;
   localparam int RF_W  = T_W - 2 * Q_FRAC;

   localparam logic signed [SB_W-1:0] ROUND_BIAS = SB_W'(1) << (2 * Q_FRAC - 1);
   localparam m_type ONE_SQ = M_WIDTH'(1) << (2 * Q_FRAC);
   localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

   // ---------------- stall control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   assign en5 = !rsp_valid_ff || rsp_tready;
   assign en4 = !s4_valid_ff || en5;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_tvalid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) rsp_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 1: quaternion products ----------------
   quat_type qx, qy, qz, qw;
   prod_type s1_prod_in, s1_prod_ff;
   logic s1_cmd_ff;
   logic signed [DATA_WIDTH-1:0] v_in [3];
   logic signed [DATA_WIDTH-1:0] s1_v_ff [3];

   assign qx = req_tdata[0 * Q_WIDTH +: Q_WIDTH];
   assign qy = req_tdata[1 * Q_WIDTH +: Q_WIDTH];
   assign qz = req_tdata[2 * Q_WIDTH +: Q_WIDTH];
   assign qw = req_tdata[3 * Q_WIDTH +: Q_WIDTH];

   assign s1_prod_in.xx = P_WIDTH'(qx) * P_WIDTH'(qx);
   assign s1_prod_in.yy = P_WIDTH'(qy) * P_WIDTH'(qy);
   assign s1_prod_in.zz = P_WIDTH'(qz) * P_WIDTH'(qz);
   assign s1_prod_in.ww = P_WIDTH'(qw) * P_WIDTH'(qw);
   assign s1_prod_in.xy = P_WIDTH'(qx) * P_WIDTH'(qy);
   assign s1_prod_in.xz = P_WIDTH'(qx) * P_WIDTH'(qz);
   assign s1_prod_in.yz = P_WIDTH'(qy) * P_WIDTH'(qz);
   assign s1_prod_in.wx = P_WIDTH'(qw) * P_WIDTH'(qx);
   assign s1_prod_in.wy = P_WIDTH'(qw) * P_WIDTH'(qy);
   assign s1_prod_in.wz = P_WIDTH'(qw) * P_WIDTH'(qz);

   for (genvar gj = 0; gj < 3; gj++) begin : g_vin
      assign v_in[gj] = req_tdata[4 * Q_WIDTH + gj * DATA_WIDTH +: DATA_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_prod_ff <= s1_prod_in;
         s1_cmd_ff  <= req_tuser;
         s1_v_ff    <= v_in;
      end
   end

   // ---------------- stage 2: rotation matrix ----------------
   m_type xx2, yy2, zz2, xy2, xz2, yz2, diag;
   m_type wx2, wy2, wz2, swx, swy, swz;
   m_type s2_m_in [3][3];
   m_type s2_m_ff [3][3];
   logic signed [DATA_WIDTH-1:0] s2_v_ff [3];

   assign xx2  = m_type'(s1_prod_ff.xx) <<< 1;
   assign yy2  = m_type'(s1_prod_ff.yy) <<< 1;
   assign zz2  = m_type'(s1_prod_ff.zz) <<< 1;
   assign xy2  = m_type'(s1_prod_ff.xy) <<< 1;
   assign xz2  = m_type'(s1_prod_ff.xz) <<< 1;
   assign yz2  = m_type'(s1_prod_ff.yz) <<< 1;
   assign wx2  = m_type'(s1_prod_ff.wx) <<< 1;
   assign wy2  = m_type'(s1_prod_ff.wy) <<< 1;
   assign wz2  = m_type'(s1_prod_ff.wz) <<< 1;
   assign diag = (m_type'(s1_prod_ff.ww) <<< 1) - ONE_SQ;

   // conjugate mode flips the sign of the cross-product terms
   assign swx = s1_cmd_ff ? wx2 : -wx2;
   assign swy = s1_cmd_ff ? wy2 : -wy2;
   assign swz = s1_cmd_ff ? wz2 : -wz2;

   assign s2_m_in[0][0] = diag + xx2;
   assign s2_m_in[0][1] = xy2 - swz;
   assign s2_m_in[0][2] = xz2 + swy;
   assign s2_m_in[1][0] = xy2 + swz;
   assign s2_m_in[1][1] = diag + yy2;
   assign s2_m_in[1][2] = yz2 - swx;
   assign s2_m_in[2][0] = xz2 - swy;
   assign s2_m_in[2][1] = yz2 + swx;
   assign s2_m_in[2][2] = diag + zz2;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_m_ff <= s2_m_in;
         s2_v_ff <= s1_v_ff;
      end
   end

   // ---------------- stage 3: partial products ----------------
   // Split each entry into a signed high part and an unsigned low part.
   logic signed [PH_W-1:0] s3_ph_in [3][3];
   logic signed [PH_W-1:0] s3_ph_ff [3][3];
   logic signed [PL_W-1:0] s3_pl_in [3][3];
   logic signed [PL_W-1:0] s3_pl_ff [3][3];

   for (genvar gi = 0; gi < 3; gi++) begin : g_row_pp
      for (genvar gj = 0; gj < 3; gj++) begin : g_col_pp
         logic signed [HI_W-1:0] m_hi;
         logic signed [LO_W:0]   m_lo;
         assign m_hi = s2_m_ff[gi][gj][M_WIDTH-1:LO_W];
         assign m_lo = {1'b0, s2_m_ff[gi][gj][LO_W-1:0]};
         assign s3_ph_in[gi][gj] = PH_W'(m_hi) * PH_W'(s2_v_ff[gj]);
         assign s3_pl_in[gi][gj] = PL_W'(m_lo) * PL_W'(s2_v_ff[gj]);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_ph_ff <= s3_ph_in;
         s3_pl_ff <= s3_pl_in;
      end
   end

   // ---------------- stage 4: row sums ----------------
   logic signed [SA_W-1:0] s4_sa_in [3];
   logic signed [SA_W-1:0] s4_sa_ff [3];
   logic signed [SB_W-1:0] s4_sb_in [3];
   logic signed [SB_W-1:0] s4_sb_ff [3];

   for (genvar gi = 0; gi < 3; gi++) begin : g_row_sum
      assign s4_sa_in[gi] = SA_W'(s3_ph_ff[gi][0]) + SA_W'(s3_ph_ff[gi][1])
                          + SA_W'(s3_ph_ff[gi][2]);
      // fold the rounding bias into the low sum
      assign s4_sb_in[gi] = SB_W'(s3_pl_ff[gi][0]) + SB_W'(s3_pl_ff[gi][1])
                          + SB_W'(s3_pl_ff[gi][2]) + ROUND_BIAS;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_sa_ff <= s4_sa_in;
         s4_sb_ff <= s4_sb_in;
      end
   end

   // ---------------- stage 5: combine, round, clip ----------------
   logic [DATA_WIDTH-1:0] r_in [3];
   logic [DATA_WIDTH-1:0] r_ff [3];
   logic [2:0] clip_hit;
   logic sat_ff;

   for (genvar gi = 0; gi < 3; gi++) begin : g_row_out
      logic signed [T_W-1:0]  total;
      logic signed [RF_W-1:0] r_full;
      logic [RF_W-DATA_WIDTH:0] upper;
      assign total    = (T_W'(s4_sa_ff[gi]) <<< LO_W) + T_W'(s4_sb_ff[gi]);
      assign r_full   = total[T_W-1:2 * Q_FRAC];
      assign upper    = r_full[RF_W-1:DATA_WIDTH-1];
      assign clip_hit[gi] = !((&upper) || !(|upper));
      assign r_in[gi] = !clip_hit[gi] ? r_full[DATA_WIDTH-1:0]
                      : (r_full[RF_W-1] ? MIN_VAL : MAX_VAL);
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         r_ff   <= r_in;
         sat_ff <= |clip_hit;
      end
   end

   assign rsp_tdata = RSP_W'({r_ff[2], r_ff[1], r_ff[0]});
   assign rsp_tuser = sat_ff;

endmodule

>>> verif/testbench.sv
// Self-checking bench for quaternion_vector_rotate: directed and random rotations with
// random idling on both channels, each result checked against a built-in predictor.
// Depends on qvr_pkg for the quaternion type and format constants.
module testbench;
   import qvr_pkg::*;

   localparam int DW        = 16;
   localparam int REQ_W     = ((4 * Q_WIDTH + 3 * DW + 7) / 8) * 8;
   localparam int RSP_W     = ((3 * DW + 7) / 8) * 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int STALL_LIMIT     = 2000;

   localparam bit ROT_INVERSE = 1'b0;
   localparam bit ROT_FORWARD = 1'b1;

   localparam quat_type Q_ZERO  = 16'sd0;
   localparam quat_type Q_ONE   = 16'sd16384;
   localparam quat_type Q_HALF  = 16'sd8192;
   localparam quat_type Q_COS45 = 16'sd11585;
   localparam quat_type Q_SIN15 = 16'sd4240;
   localparam quat_type Q_COS15 = 16'sd15826;
   localparam quat_type Q_MAX   = 16'sh7fff;
   localparam quat_type Q_MIN   = 16'sh8000;

   localparam logic signed [DW-1:0] V_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] V_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef logic signed [DW-1:0] vec_type;

   typedef struct packed {
      vec_type rx;
      vec_type ry;
      vec_type rz;
      logic    saturated;
   } rotation_type;

   class rotation_scoreboard;
      rotation_type expected_q[$];
      int           mismatches = 0;

      // Exact product sum, round half up at 2^-28, then clip to DW bits.
      function rotation_type rotate_vector(bit cmd, quat_type qx, quat_type qy,
                                           quat_type qz, quat_type qw,
                                           vec_type vx, vec_type vy, vec_type vz);
         longint       x, y, z, w, sgn, diag, acc, hi, lo;
         longint       m[3][3];
         longint       v[3];
         vec_type      r[3];
         rotation_type res;
         x = qx;  y = qy;  z = qz;  w = qw;
         v[0] = vx;  v[1] = vy;  v[2] = vz;
         sgn = cmd ? 64'sd1 : -64'sd1;
         hi = (longint'(1) <<< (DW - 1)) - 1;
         lo = -hi - 1;
         diag = 2 * w * w - (longint'(1) <<< (2 * Q_FRAC));
         m[0][0] = diag + 2 * x * x;
         m[0][1] = 2 * x * y - sgn * 2 * w * z;
         m[0][2] = 2 * x * z + sgn * 2 * w * y;
         m[1][0] = 2 * x * y + sgn * 2 * w * z;
         m[1][1] = diag + 2 * y * y;
         m[1][2] = 2 * y * z - sgn * 2 * w * x;
         m[2][0] = 2 * x * z - sgn * 2 * w * y;
         m[2][1] = 2 * y * z + sgn * 2 * w * x;
         m[2][2] = diag + 2 * z * z;
         res.saturated = 1'b0;
         for (int i = 0; i < 3; i++) begin
            acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2]
                  + (longint'(1) <<< (2 * Q_FRAC - 1));
            acc = acc >>> (2 * Q_FRAC);
            if (acc > hi) begin
               acc = hi;
               res.saturated = 1'b1;
            end else if (acc < lo) begin
               acc = lo;
               res.saturated = 1'b1;
            end
            r[i] = acc[DW-1:0];
         end
         res.rx = r[0];
         res.ry = r[1];
         res.rz = r[2];
         return res;
      endfunction

      function void note_request(bit cmd, quat_type qx, quat_type qy, quat_type qz,
                                 quat_type qw, vec_type vx, vec_type vy, vec_type vz);
         expected_q.insert(expected_q.size(),
                           rotate_vector(cmd, qx, qy, qz, qw, vx, vy, vz));
      endfunction

      function void check_result(logic [RSP_W-1:0] data, logic sat);
         rotation_type got, want;
         got.rx = data[DW-1:0];
         got.ry = data[2*DW-1:DW];
         got.rz = data[3*DW-1:2*DW];
         got.saturated = sat;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with none pending: (%0d %0d %0d) sat %0b",
                     $time, got.rx, got.ry, got.rz, got.saturated);
            return;
         end
         want = expected_q.pop_front();
         if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz
             || got.saturated !== want.saturated) begin
            mismatches++;
            $display("%0t: expected (%0d %0d %0d) sat %0b, got (%0d %0d %0d) sat %0b",
                     $time, want.rx, want.ry, want.rz, want.saturated,
                     got.rx, got.ry, got.rz, got.saturated);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;

   rotation_scoreboard sb = new;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;

   quaternion_vector_rotate #(.DATA_WIDTH(DW)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Called just after a falling edge; returns just after a falling edge.
   task send_rotation(input bit cmd, input quat_type qx, input quat_type qy,
                      input quat_type qz, input quat_type qw,
                      input vec_type vx, input vec_type vy, input vec_type vz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = REQ_W'({$urandom, $urandom, $urandom, $urandom});
         req_tuser  = 1'($urandom);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = REQ_W'({vz, vy, vx, qw, qz, qy, qx});
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, qx, qy, qz, qw, vx, vy, vz);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Count cycles without any transfer; end the run if the block hangs.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   initial begin
      int      a, b, c, d, kind;
      real     norm;
      bit      cmd;
      quat_type qx, qy, qz, qw;
      vec_type vx, vy, vz;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      rsp_tready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 49;

      // Identity both ways, full-scale vector
      send_rotation(ROT_FORWARD, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, V_MAX, V_MIN, DW'(1));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, V_MAX, V_MIN, DW'(1));
      // Zero quaternion negates the vector; negating the minimum clips
      send_rotation(ROT_FORWARD, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, V_MIN, V_MAX, DW'(0));
      // Non-unit extremes saturate, except with a zero vector
      send_rotation(ROT_FORWARD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, V_MAX, V_MAX, V_MAX);
      send_rotation(ROT_INVERSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, V_MIN, V_MIN, V_MIN);
      send_rotation(ROT_FORWARD, Q_MIN, Q_MAX, Q_MIN, Q_MAX, V_MAX, V_MIN, V_MAX);
      send_rotation(ROT_INVERSE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, DW'(0), DW'(0), DW'(0));
      // Half-way ties: w = 0.5 scales v by -1/2
      send_rotation(ROT_FORWARD, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF, DW'(1), DW'(-1), DW'(3));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF, DW'(-3), DW'(5), V_MIN);
      // Quarter turn about z, both directions
      send_rotation(ROT_FORWARD, Q_ZERO, Q_ZERO, Q_COS45, Q_COS45, DW'(16384), DW'(0), DW'(0));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_ZERO, Q_COS45, Q_COS45, DW'(16384), DW'(0), DW'(0));
      // Half turns about each axis
      send_rotation(ROT_FORWARD, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, DW'(100), DW'(200), DW'(300));
      send_rotation(ROT_FORWARD, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO, DW'(100), DW'(200), DW'(300));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO, V_MAX, V_MIN, DW'(-7));
      // Projected gravity
      send_rotation(ROT_INVERSE, Q_SIN15, Q_ZERO, Q_ZERO, Q_COS15, DW'(0), DW'(0), DW'(-16384));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, DW'(0), DW'(0), DW'(-1));
      send_rotation(ROT_INVERSE, Q_ZERO, Q_SIN15, Q_ZERO, Q_COS15, DW'(0), DW'(0), DW'(-1));

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 28 : 0;
         repeat (ITEMS_PER_PHASE) begin
            cmd  = 1'($urandom);
            kind = $urandom_range(9);
            if (kind < 2) begin
               // any bit pattern, mostly saturating
               qx = quat_type'($urandom);
               qy = quat_type'($urandom);
               qz = quat_type'($urandom);
               qw = quat_type'($urandom);
            end else if (kind < 4) begin
               qx = quat_type'(int'($urandom_range(24000)) - 12000);
               qy = quat_type'(int'($urandom_range(24000)) - 12000);
               qz = quat_type'(int'($urandom_range(24000)) - 12000);
               qw = quat_type'(int'($urandom_range(24000)) - 12000);
            end else begin
               // near-unit rotation
               a = int'($urandom_range(32768)) - 16384;
               b = int'($urandom_range(32768)) - 16384;
               c = int'($urandom_range(32768)) - 16384;
               d = int'($urandom_range(32768)) - 16384;
               norm = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c + real'(d) * d);
               if (norm < 1.0) begin
                  a = 0;  b = 0;  c = 0;  d = 16384;  norm = 16384.0;
               end
               qx = quat_type'($rtoi(a * 16384.0 / norm));
               qy = quat_type'($rtoi(b * 16384.0 / norm));
               qz = quat_type'($rtoi(c * 16384.0 / norm));
               qw = quat_type'($rtoi(d * 16384.0 / norm));
            end
            if ($urandom_range(3) == 0) begin
               vx = DW'(int'($urandom_range(256)) - 128);
               vy = DW'(int'($urandom_range(256)) - 128);
               vz = DW'(int'($urandom_range(256)) - 128);
            end else begin
               vx = DW'($urandom);
               vy = DW'($urandom);
               vz = DW'($urandom);
            end
            send_rotation(cmd, qx, qy, qz, qw, vx, vy, vz);
         end
      end
      req_tvalid = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      // let any stray result surface
      repeat (12) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end
endmodule
